// ===== hw/rtl/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg: closest point on triangle, shared types and arithmetic helpers
// Widths of the exact intermediate terms, queue sizing, region codes and the
// chunked multiply helpers used by the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

    localparam int CW    = 32;               // coordinate width
    localparam int DW    = CW + 1;           // vertex difference
    localparam int PW    = 2 * DW;           // difference product
    localparam int DOTW  = PW + 2;           // dot product d1..d6
    localparam int HW    = DOTW / 2;         // half of a dot product
    localparam int BPW   = 2 * DOTW;         // product of two dot products
    localparam int BW    = BPW + 1;          // va, vb, vc
    localparam int EW    = DOTW + 1;         // d4-d3, d5-d6
    localparam int DENW  = BW + 2;           // any denominator
    localparam int NCH   = (BW + CW - 1) / CW;   // chunks of s or t
    localparam int NUMW  = BW + DW + 1;      // s*U + t*V
    localparam int QB    = CW + 2;           // quotient bits before saturation
    localparam int RW    = DENW + QB + 1;    // partial remainder
    localparam int XW    = QB + 3;           // base plus signed quotient
    localparam int IN_W  = 12 * CW;
    localparam int OUT_W = 3 * CW;

    localparam int QDEPTH = 16;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam logic signed [CW-1:0] CRD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CRD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [2:0] {
        RG_A, RG_B, RG_C, RG_AB, RG_AC, RG_BC, RG_INT
    } region_t;

    typedef logic [2:0][CW-1:0]   crd3_t;
    typedef logic [2:0][DW-1:0]   dif3_t;
    typedef logic [5:0][DOTW-1:0] dot6_t;
    typedef logic [NCH-1:0][PW-1:0] pp_set_t;

    typedef struct packed {
        logic [2*HW-1:0] hh;
        logic [2*HW:0]   hl;
        logic [2*HW:0]   lh;
        logic [2*HW-1:0] ll;
    } bpp_t;

    typedef struct packed {
        crd3_t a;
        crd3_t b;
        crd3_t c;
        dif3_t ab;
        dif3_t ac;
        dif3_t cb;
    } geo_t;

    // one classified query, handed from the front to the back
    typedef struct packed {
        region_t         region;
        crd3_t           base;
        dif3_t           u;
        dif3_t           v;
        logic [BW-1:0]   s;
        logic [BW-1:0]   t;
        logic [DENW-1:0] den;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    function automatic logic [DW-1:0] dif(input logic [CW-1:0] x, input logic [CW-1:0] y);
        logic signed [DW-1:0] r;
        r = DW'($signed(x)) - DW'($signed(y));
        return r;
    endfunction

    function automatic logic [PW-1:0] mul_d(input logic [DW-1:0] x, input logic [DW-1:0] y);
        logic signed [PW-1:0] r;
        r = $signed(x) * $signed(y);
        return r;
    endfunction

    function automatic logic [DOTW-1:0] sum3(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                             input logic [PW-1:0] z);
        logic signed [DOTW-1:0] r;
        r = DOTW'($signed(x)) + DOTW'($signed(y)) + DOTW'($signed(z));
        return r;
    endfunction

    // 68x68 signed product as four partial products of about 34x34
    function automatic bpp_t mul_parts(input logic [DOTW-1:0] x, input logic [DOTW-1:0] y);
        bpp_t r;
        logic signed [2*HW-1:0] hh;
        logic signed [2*HW:0]   hl;
        logic signed [2*HW:0]   lh;
        hh = $signed(x[DOTW-1:HW]) * $signed(y[DOTW-1:HW]);
        hl = $signed(x[DOTW-1:HW]) * $signed({1'b0, y[HW-1:0]});
        lh = $signed({1'b0, x[HW-1:0]}) * $signed(y[DOTW-1:HW]);
        r.hh = hh;
        r.hl = hl;
        r.lh = lh;
        r.ll = x[HW-1:0] * y[HW-1:0];
        return r;
    endfunction

    function automatic logic [BPW-1:0] join_parts(input bpp_t p);
        logic [BPW-1:0] mid;
        mid = BPW'($signed(p.hl)) + BPW'($signed(p.lh));
        return {p.hh, {(2*HW){1'b0}}} + (mid << HW) + {{(2*HW){1'b0}}, p.ll};
    endfunction

    // s (BW bits) times one difference, one partial product per 32-bit chunk
    function automatic pp_set_t mul_chunks(input logic [BW-1:0] s, input logic [DW-1:0] u);
        pp_set_t p;
        logic signed [PW-1:0] r;
        for (int i = 0; i < NCH - 1; i++) begin
            r = $signed({1'b0, s[i*CW +: CW]}) * $signed(u);
            p[i] = r;
        end
        r = $signed(s[BW-1:(NCH-1)*CW]) * $signed(u);
        p[NCH-1] = r;
        return p;
    endfunction

    function automatic logic [NUMW-1:0] sum_chunks(input pp_set_t p);
        logic [NUMW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NCH; i++) begin
            acc = acc + (NUMW'($signed(p[i])) << (i * CW));
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/closest_point_on_triangle_top.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_triangle_top: nearest point of a triangle to a query
// Usage:
//   The slave stream carries one query per beat: point P and vertices A, B,
//   C, twelve signed Q16.16 words packed in s_tdata from point_x upward.
//   The master stream returns one beat per query: the nearest point
//   (near_x, near_y, near_z) in m_tdata and its Voronoi region code in
//   m_tuser (A, B, C, edge AB, AC, BC, interior).
//   Throughput is one query per cycle while m_tready stays high. Each query
//   passes the classifier stages f1 to f7, the job queue and its registered
//   read port, then the interpolator stages b2 to b5, the divider stages,
//   one quotient bit each, the rounding stage and the output register.
//   While m_tvalid waits on m_tready the interpolator holds; the 16-entry
//   job queue keeps absorbing classified queries and s_tready drops once the
//   queue and the classifier stages together hold 16 queries.
//   Reset (aresetn low, synchronous) empties the pipeline and queue; no
//   beats are lost or duplicated across stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_triangle_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [cpt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // near_x, near_y, near_z
    output logic [cpt_pkg::OUT_W-1:0]  m_tdata,
    // region
    output logic [2:0]                 m_tuser
);
    import cpt_pkg::*;

    q_wr_t      q_wr;
    job_t       q_rdata;
    fifo_stat_t q_st;
    logic       pop;

    cpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .q_wr     (q_wr)
    );

    cpt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .rdata   (q_rdata),
        .st      (q_st)
    );

    cpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_st     (q_st),
        .q_rdata  (q_rdata),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_front.sv =====
// ----------------------------------------------------------------------------
// cpt_front: query intake and region classification
// Forms edge vectors, dot products and barycentric terms exactly, picks the
// Voronoi region and writes the interpolation job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // P.xyz, A.xyz, B.xyz, C.xyz, 32 bits each, point_x lowest
    input  logic [cpt_pkg::IN_W-1:0]  s_tdata,
    input  logic                      pop,
    output cpt_pkg::q_wr_t            q_wr
);
    import cpt_pkg::*;

    typedef struct packed {
        geo_t  g;
        dif3_t ap;
        dif3_t bp;
        dif3_t cp;
    } f1_t;

    typedef struct packed {
        geo_t               g;
        logic [17:0][PW-1:0] pr;
    } f2_t;

    typedef struct packed {
        geo_t  g;
        dot6_t d;
    } f3_t;

    typedef struct packed {
        geo_t       g;
        dot6_t      d;
        bpp_t [5:0] pp;
    } f4_t;

    typedef struct packed {
        geo_t                g;
        dot6_t               d;
        logic [5:0][BPW-1:0] bp;
    } f5_t;

    typedef struct packed {
        geo_t          g;
        dot6_t         d;
        logic [BW-1:0] va;
        logic [BW-1:0] vb;
        logic [BW-1:0] vc;
        logic [EW-1:0] e1;
        logic [EW-1:0] e2;
    } f6_t;

    f1_t  f1_reg, f1_next;
    f2_t  f2_reg, f2_next;
    f3_t  f3_reg, f3_next;
    f4_t  f4_reg, f4_next;
    f5_t  f5_reg, f5_next;
    f6_t  f6_reg, f6_next;
    job_t f7_reg, f7_next;
    logic [6:0] vld_reg, vld_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic acc;

    // credit count covers every item in the front stages plus the queue
    assign s_tready = (cnt_reg < QCW'(QDEPTH));
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        crd3_t p;
        for (int k = 0; k < 3; k++) begin
            p[k]         = s_tdata[k*CW +: CW];
            f1_next.g.a[k] = s_tdata[(3+k)*CW +: CW];
            f1_next.g.b[k] = s_tdata[(6+k)*CW +: CW];
            f1_next.g.c[k] = s_tdata[(9+k)*CW +: CW];
        end
        for (int k = 0; k < 3; k++) begin
            f1_next.g.ab[k] = dif(f1_next.g.b[k], f1_next.g.a[k]);
            f1_next.g.ac[k] = dif(f1_next.g.c[k], f1_next.g.a[k]);
            f1_next.g.cb[k] = dif(f1_next.g.c[k], f1_next.g.b[k]);
            f1_next.ap[k]   = dif(p[k], f1_next.g.a[k]);
            f1_next.bp[k]   = dif(p[k], f1_next.g.b[k]);
            f1_next.cp[k]   = dif(p[k], f1_next.g.c[k]);
        end
    end

    // d1 = AB.AP, d2 = AC.AP, d3 = AB.BP, d4 = AC.BP, d5 = AB.CP, d6 = AC.CP
    always_comb begin
        f2_next.g = f1_reg.g;
        for (int k = 0; k < 3; k++) begin
            f2_next.pr[0+k]  = mul_d(f1_reg.g.ab[k], f1_reg.ap[k]);
            f2_next.pr[3+k]  = mul_d(f1_reg.g.ac[k], f1_reg.ap[k]);
            f2_next.pr[6+k]  = mul_d(f1_reg.g.ab[k], f1_reg.bp[k]);
            f2_next.pr[9+k]  = mul_d(f1_reg.g.ac[k], f1_reg.bp[k]);
            f2_next.pr[12+k] = mul_d(f1_reg.g.ab[k], f1_reg.cp[k]);
            f2_next.pr[15+k] = mul_d(f1_reg.g.ac[k], f1_reg.cp[k]);
        end
    end

    always_comb begin
        f3_next.g = f2_reg.g;
        for (int n = 0; n < 6; n++) begin
            f3_next.d[n] = sum3(f2_reg.pr[3*n], f2_reg.pr[3*n+1], f2_reg.pr[3*n+2]);
        end
    end

    // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
    always_comb begin
        f4_next.g     = f3_reg.g;
        f4_next.d     = f3_reg.d;
        f4_next.pp[0] = mul_parts(f3_reg.d[0], f3_reg.d[3]);
        f4_next.pp[1] = mul_parts(f3_reg.d[2], f3_reg.d[1]);
        f4_next.pp[2] = mul_parts(f3_reg.d[4], f3_reg.d[1]);
        f4_next.pp[3] = mul_parts(f3_reg.d[0], f3_reg.d[5]);
        f4_next.pp[4] = mul_parts(f3_reg.d[2], f3_reg.d[5]);
        f4_next.pp[5] = mul_parts(f3_reg.d[4], f3_reg.d[3]);
    end

    always_comb begin
        f5_next.g = f4_reg.g;
        f5_next.d = f4_reg.d;
        for (int n = 0; n < 6; n++) begin
            f5_next.bp[n] = join_parts(f4_reg.pp[n]);
        end
    end

    always_comb begin
        logic signed [BW-1:0] t0;
        f6_next.g  = f5_reg.g;
        f6_next.d  = f5_reg.d;
        t0         = BW'($signed(f5_reg.bp[0])) - BW'($signed(f5_reg.bp[1]));
        f6_next.vc = t0;
        t0         = BW'($signed(f5_reg.bp[2])) - BW'($signed(f5_reg.bp[3]));
        f6_next.vb = t0;
        t0         = BW'($signed(f5_reg.bp[4])) - BW'($signed(f5_reg.bp[5]));
        f6_next.va = t0;
        f6_next.e1 = EW'($signed(f5_reg.d[3])) - EW'($signed(f5_reg.d[2]));
        f6_next.e2 = EW'($signed(f5_reg.d[4])) - EW'($signed(f5_reg.d[5]));
    end

    // region selection, in priority order
    always_comb begin
        logic signed [DOTW-1:0] d1, d2, d3, d6;
        logic signed [EW-1:0]   e1, e2;
        logic signed [BW-1:0]   va, vb, vc;
        d1 = f6_reg.d[0];
        d2 = f6_reg.d[1];
        d3 = f6_reg.d[2];
        d6 = f6_reg.d[5];
        e1 = f6_reg.e1;
        e2 = f6_reg.e2;
        va = f6_reg.va;
        vb = f6_reg.vb;
        vc = f6_reg.vc;
        f7_next.region = RG_A;
        f7_next.base   = f6_reg.g.a;
        f7_next.u      = f6_reg.g.ab;
        f7_next.v      = f6_reg.g.ac;
        f7_next.s      = '0;
        f7_next.t      = '0;
        f7_next.den    = '0;
        if ((d1 <= 0) && (d2 <= 0)) begin
            f7_next.region = RG_A;
        end else if ((d3 >= 0) && (e1 <= 0)) begin
            f7_next.region = RG_B;
            f7_next.base   = f6_reg.g.b;
        end else if ((d6 >= 0) && (e2 <= 0)) begin
            f7_next.region = RG_C;
            f7_next.base   = f6_reg.g.c;
        end else if ((vc <= 0) && (d1 >= 0) && (d3 <= 0)) begin
            f7_next.region = RG_AB;
            f7_next.s      = BW'(d1);
            f7_next.den    = DENW'(d1) - DENW'(d3);
        end else if ((vb <= 0) && (d2 >= 0) && (d6 <= 0)) begin
            f7_next.region = RG_AC;
            f7_next.u      = f6_reg.g.ac;
            f7_next.s      = BW'(d2);
            f7_next.den    = DENW'(d2) - DENW'(d6);
        end else if ((va <= 0) && (e1 >= 0) && (e2 >= 0)) begin
            f7_next.region = RG_BC;
            f7_next.base   = f6_reg.g.b;
            f7_next.u      = f6_reg.g.cb;
            f7_next.s      = BW'(e1);
            f7_next.den    = DENW'(e1) + DENW'(e2);
        end else begin
            f7_next.region = RG_INT;
            f7_next.s      = vb;
            f7_next.t      = vc;
            f7_next.den    = DENW'(va) + DENW'(vb) + DENW'(vc);
        end
    end

    always_comb begin
        vld_next = {vld_reg[5:0], acc};
        cnt_next = cnt_reg + QCW'(acc) - QCW'(pop);
    end

    always_ff @(posedge aclk) begin
        f1_reg <= f1_next;
        f2_reg <= f2_next;
        f3_reg <= f3_next;
        f4_reg <= f4_next;
        f5_reg <= f5_next;
        f6_reg <= f6_next;
        f7_reg <= f7_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    assign q_wr.valid = vld_reg[6];
    assign q_wr.job   = f7_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCW'(QDEPTH))
        else $error("front credit count above queue depth");

    a_pop_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cnt_reg != '0))
        else $error("queue pop without an outstanding item");

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_fifo.sv =====
// ----------------------------------------------------------------------------
// cpt_fifo: job queue between the classifier and the interpolator
// Synchronous queue of classified jobs with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cpt_pkg::q_wr_t         q_wr,
    input  logic                   pop,
    output cpt_pkg::job_t          rdata,
    output cpt_pkg::fifo_stat_t    st
);
    import cpt_pkg::*;

    job_t mem [QDEPTH];
    job_t rdata_reg;
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QAW'(q_wr.valid);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        cnt_next    = cnt_reg + QCW'(q_wr.valid) - QCW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (q_wr.valid) begin
            mem[wr_ptr_reg] <= q_wr.job;
        end
        if (pop) begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign rdata    = rdata_reg;
    assign st.empty = (cnt_reg == '0);
    assign st.full  = (cnt_reg == QCW'(QDEPTH));

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.valid |-> !st.full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !st.empty)
        else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_back.sv =====
// ----------------------------------------------------------------------------
// cpt_back: interpolation, rounded division and saturation
// Forms s*U + t*V, divides by the denominator one quotient bit per stage,
// rounds, adds the base vertex and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cpt_pkg::fifo_stat_t        q_st,
    input  cpt_pkg::job_t              q_rdata,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // near_x, near_y, near_z, 32 bits each, near_x lowest
    output logic [cpt_pkg::OUT_W-1:0]  m_tdata,
    // region
    output logic [2:0]                 m_tuser
);
    import cpt_pkg::*;

    typedef struct packed {
        region_t         region;
        crd3_t           base;
        logic            is_div;
        logic [DENW-1:0] den;
        logic [2:0]      ps_unused;
    } hdr_t;

    typedef struct packed {
        region_t         region;
        crd3_t           base;
        logic            is_div;
        logic [DENW-1:0] den;
    } cmn_t;

    typedef struct packed {
        cmn_t               c;
        pp_set_t [2:0]      ps;
        pp_set_t [2:0]      pt;
    } b2_t;

    typedef struct packed {
        cmn_t                 c;
        logic [2:0][NUMW-1:0] sp;
        logic [2:0][NUMW-1:0] tp;
    } b3_t;

    typedef struct packed {
        cmn_t                 c;
        logic [2:0][NUMW-1:0] num;
    } b4_t;

    typedef struct packed {
        region_t              region;
        crd3_t                base;
        logic                 is_div;
        logic [DENW-1:0]      dmag;
        logic [2:0]           neg;
        logic [2:0][NUMW-1:0] nmag;
    } b5_t;

    typedef struct packed {
        region_t            region;
        crd3_t              base;
        logic               is_div;
        logic [DENW-1:0]    dmag;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [2:0][QB-1:0] q;
        logic [2:0][RW-1:0] r;
    } dv_t;

    typedef struct packed {
        region_t          region;
        crd3_t            base;
        logic             is_div;
        logic [2:0]       neg;
        logic [2:0]       ovf;
        logic [2:0][QB:0] qr;
    } rn_t;

    logic adv;
    logic b1_vld_reg, b2_vld_reg, b3_vld_reg, b4_vld_reg, b5_vld_reg, rn_vld_reg;
    logic [QB:0] dv_vld_reg;
    b2_t  b2_reg, b2_next;
    b3_t  b3_reg, b3_next;
    b4_t  b4_reg, b4_next;
    b5_t  b5_reg, b5_next;
    dv_t  dv_reg [QB+1];
    dv_t  dv0_next;
    rn_t  rn_reg, rn_next;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg;
    region_t              m_region_next;

    // whole back pipeline advances together; the output register parts it
    // from the receiver
    assign adv = !m_tvalid_reg || m_tready;
    assign pop = adv && !q_st.empty;

    always_comb begin
        b2_next.c.base   = q_rdata.base;
        b2_next.c.den    = q_rdata.den;
        b2_next.c.is_div = (q_rdata.den != '0);
        // zero interior denominator: degenerate triangle falls back to A
        b2_next.c.region = ((q_rdata.region == RG_INT) && (q_rdata.den == '0)) ?
                           RG_A : q_rdata.region;
        for (int k = 0; k < 3; k++) begin
            b2_next.ps[k] = mul_chunks(q_rdata.s, q_rdata.u[k]);
            b2_next.pt[k] = mul_chunks(q_rdata.t, q_rdata.v[k]);
        end
    end

    always_comb begin
        b3_next.c = b2_reg.c;
        for (int k = 0; k < 3; k++) begin
            b3_next.sp[k] = sum_chunks(b2_reg.ps[k]);
            b3_next.tp[k] = sum_chunks(b2_reg.pt[k]);
        end
    end

    always_comb begin
        b4_next.c = b3_reg.c;
        for (int k = 0; k < 3; k++) begin
            b4_next.num[k] = b3_reg.sp[k] + b3_reg.tp[k];
        end
    end

    always_comb begin
        logic dneg;
        dneg           = b4_reg.c.den[DENW-1];
        b5_next.region = b4_reg.c.region;
        b5_next.base   = b4_reg.c.base;
        b5_next.is_div = b4_reg.c.is_div;
        b5_next.dmag   = dneg ? (~b4_reg.c.den + 1'b1) : b4_reg.c.den;
        for (int k = 0; k < 3; k++) begin
            b5_next.neg[k]  = b4_reg.num[k][NUMW-1] ^ dneg;
            b5_next.nmag[k] = b4_reg.num[k][NUMW-1] ? (~b4_reg.num[k] + 1'b1) : b4_reg.num[k];
        end
    end

    // quotient at or beyond 2^QB saturates whatever the base
    always_comb begin
        dv0_next.region = b5_reg.region;
        dv0_next.base   = b5_reg.base;
        dv0_next.is_div = b5_reg.is_div;
        dv0_next.dmag   = b5_reg.dmag;
        dv0_next.neg    = b5_reg.neg;
        dv0_next.q      = '0;
        for (int k = 0; k < 3; k++) begin
            dv0_next.r[k]   = RW'(b5_reg.nmag[k]);
            dv0_next.ovf[k] = RW'(b5_reg.nmag[k]) >= (RW'(b5_reg.dmag) << QB);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            b4_reg    <= b4_next;
            b5_reg    <= b5_next;
            dv_reg[0] <= dv0_next;
        end
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        dv_t dv_next;

        always_comb begin
            dv_next = dv_reg[j];
            for (int k = 0; k < 3; k++) begin
                if (dv_reg[j].r[k] >= (RW'(dv_reg[j].dmag) << BIT)) begin
                    dv_next.r[k]      = dv_reg[j].r[k] - (RW'(dv_reg[j].dmag) << BIT);
                    dv_next.q[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    // round to nearest, ties away from zero, on the magnitude
    always_comb begin
        rn_next.region = dv_reg[QB].region;
        rn_next.base   = dv_reg[QB].base;
        rn_next.is_div = dv_reg[QB].is_div;
        rn_next.neg    = dv_reg[QB].neg;
        rn_next.ovf    = dv_reg[QB].ovf;
        for (int k = 0; k < 3; k++) begin
            rn_next.qr[k] = {1'b0, dv_reg[QB].q[k]} +
                (QB+1)'({dv_reg[QB].r[k][DENW-1:0], 1'b0} >= {1'b0, dv_reg[QB].dmag});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rn_reg <= rn_next;
        end
    end

    always_comb begin
        logic signed [QB+1:0]  sq;
        logic signed [XW-1:0]  x;
        logic signed [CW-1:0]  y;
        m_region_next = rn_reg.region;
        for (int k = 0; k < 3; k++) begin
            sq = rn_reg.neg[k] ? -$signed({1'b0, rn_reg.qr[k]}) : $signed({1'b0, rn_reg.qr[k]});
            x  = XW'($signed(rn_reg.base[k])) + XW'(sq);
            if (!rn_reg.is_div) begin
                y = rn_reg.base[k];
            end else if (rn_reg.ovf[k]) begin
                y = rn_reg.neg[k] ? CRD_MIN : CRD_MAX;
            end else if (x > XW'(CRD_MAX)) begin
                y = CRD_MAX;
            end else if (x < XW'(CRD_MIN)) begin
                y = CRD_MIN;
            end else begin
                y = x[CW-1:0];
            end
            m_tdata_next[k*CW +: CW] = y;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_region_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg   <= 1'b0;
            b2_vld_reg   <= 1'b0;
            b3_vld_reg   <= 1'b0;
            b4_vld_reg   <= 1'b0;
            b5_vld_reg   <= 1'b0;
            dv_vld_reg   <= '0;
            rn_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            b1_vld_reg   <= pop;
            b2_vld_reg   <= b1_vld_reg;
            b3_vld_reg   <= b2_vld_reg;
            b4_vld_reg   <= b3_vld_reg;
            b5_vld_reg   <= b4_vld_reg;
            dv_vld_reg   <= {dv_vld_reg[QB-1:0], b5_vld_reg};
            rn_vld_reg   <= dv_vld_reg[QB];
            m_tvalid_reg <= rn_vld_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_region_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg <= 3'(RG_INT)))
        else $error("region code out of range");

endmodule

`default_nettype wire
